[design/length_prefixed_frame_splitter_core_macros.svh]
// ----------------------------------------------------------------------------
// Assertion macros for the frame splitter checker
// Shorthand for clocked implications with reset gating.
// ----------------------------------------------------------------------------
`ifndef LENGTH_PREFIXED_FRAME_SPLITTER_CORE_MACROS_SVH
`define LENGTH_PREFIXED_FRAME_SPLITTER_CORE_MACROS_SVH

// same-cycle implication
`define LPFS_ASSERT_NOW(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("frame splitter check failed");

// next-cycle implication
`define LPFS_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("frame splitter check failed");

`endif

[design/lpfs_pkg.sv]
// ----------------------------------------------------------------------------
// lpfs_pkg
// Shared types and constants for the length-prefixed frame splitter.
// ----------------------------------------------------------------------------
package lpfs_pkg;

  localparam logic [15:0] PREFIX_LEN    = 16'd4;
  localparam logic [15:0] MAX_LEN_RESET = 16'hFFFF;
  localparam int          RES_DEPTH     = 4;

  localparam logic [1:0] ERR_NONE      = 2'd0;
  localparam logic [1:0] ERR_TOO_LONG  = 2'd1;
  localparam logic [1:0] ERR_TOO_SHORT = 2'd2;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       first_of_frame;
    logic       last_of_frame;
    logic [1:0] error_code;
  } res_t;

endpackage

[design/length_prefixed_frame_splitter_core.sv]
// ----------------------------------------------------------------------------
// length_prefixed_frame_splitter_core: one byte per cycle when in_ready; results
// are registered. Body bytes stream at 1/cycle while out_ready is high; the 4th
// prefix byte fills the 4-entry queue (1 entry on bad length); input waits.
// Sync active-high reset clears framing state, queue, and sets max to 65535.
// ----------------------------------------------------------------------------
module length_prefixed_frame_splitter_core
  import lpfs_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [15:0] cfg_data,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  data_byte,
  input  logic        restart,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [7:0]  out_byte,
  output logic        first_of_frame,
  output logic        last_of_frame,
  output logic [1:0]  error_code
);

  logic [15:0] max_frame_length;
  logic [23:0] prefix_bytes;
  logic [1:0]  prefix_position;
  logic [15:0] bytes_remaining;
  logic        in_body;
  logic        discarding;

  logic [23:0] prefix_bytes_next;
  logic [1:0]  prefix_position_next;
  logic [15:0] bytes_remaining_next;
  logic        in_body_next;
  logic        discarding_next;

  // state as seen after an optional restart
  logic [23:0] eff_prefix;
  logic [1:0]  eff_pos;
  logic [15:0] eff_rem;
  logic        eff_body;
  logic        eff_disc;

  logic [15:0] len_low;
  logic        too_short;
  logic        too_long;

  res_t        res [RES_DEPTH];
  logic [2:0]  n_res;

  res_t        q [RES_DEPTH];
  logic [2:0]  cnt;
  logic        in_fire;
  logic        out_fire;

  assign cfg_ready = 1'b1;

  assign out_valid = (cnt != 3'd0);
  assign out_fire  = out_valid && out_ready;
  // room for up to four results once the queue is empty or about to be
  assign in_ready  = (cnt == 3'd0) || ((cnt == 3'd1) && out_ready);
  assign in_fire   = in_valid && in_ready;

  assign out_byte       = q[0].out_byte;
  assign first_of_frame = q[0].first_of_frame;
  assign last_of_frame  = q[0].last_of_frame;
  assign error_code     = q[0].error_code;

  assign eff_prefix = restart ? 24'd0 : prefix_bytes;
  assign eff_pos    = restart ? 2'd0  : prefix_position;
  assign eff_rem    = restart ? 16'd0 : bytes_remaining;
  assign eff_body   = restart ? 1'b0  : in_body;
  assign eff_disc   = restart ? 1'b0  : discarding;

  assign len_low   = {eff_prefix[7:0], data_byte};
  assign too_short = (eff_prefix == 24'd0) && (data_byte < 8'd4);
  assign too_long  = (eff_prefix[23:8] != 16'd0) || (len_low > max_frame_length);

  always_comb begin
    prefix_bytes_next    = eff_prefix;
    prefix_position_next = eff_pos;
    bytes_remaining_next = eff_rem;
    in_body_next         = eff_body;
    discarding_next      = eff_disc;
    n_res                = 3'd0;
    for (int k = 0; k < RES_DEPTH; k++) begin
      res[k] = '0;
    end

    if (eff_disc) begin
      n_res = 3'd0;
    end else if (eff_body) begin
      res[0].out_byte      = data_byte;
      res[0].last_of_frame = (eff_rem <= 16'd1);
      res[0].error_code    = ERR_NONE;
      n_res                = 3'd1;
      if (eff_rem != 16'd0) begin
        bytes_remaining_next = eff_rem - 16'd1;
      end
      in_body_next = (bytes_remaining_next != 16'd0);
    end else if (eff_pos != 2'd3) begin
      prefix_bytes_next    = {eff_prefix[15:0], data_byte};
      prefix_position_next = eff_pos + 2'd1;
    end else begin
      prefix_position_next = 2'd0;
      n_res                = 3'd1;
      if (too_short) begin
        res[0].error_code = ERR_TOO_SHORT;
        discarding_next   = 1'b1;
      end else if (too_long) begin
        res[0].error_code = ERR_TOO_LONG;
        discarding_next   = 1'b1;
      end else begin
        res[0].out_byte       = eff_prefix[23:16];
        res[0].first_of_frame = 1'b1;
        res[1].out_byte       = eff_prefix[15:8];
        res[2].out_byte       = eff_prefix[7:0];
        res[3].out_byte       = data_byte;
        res[3].last_of_frame  = (len_low == PREFIX_LEN);
        n_res                 = 3'd4;
        bytes_remaining_next  = len_low - PREFIX_LEN;
        in_body_next          = (bytes_remaining_next != 16'd0);
        prefix_bytes_next     = 24'd0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      max_frame_length <= MAX_LEN_RESET;
    end else if (cfg_valid && cfg_ready) begin
      max_frame_length <= cfg_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      prefix_bytes    <= 24'd0;
      prefix_position <= 2'd0;
      bytes_remaining <= 16'd0;
      in_body         <= 1'b0;
      discarding      <= 1'b0;
    end else if (in_fire) begin
      prefix_bytes    <= prefix_bytes_next;
      prefix_position <= prefix_position_next;
      bytes_remaining <= bytes_remaining_next;
      in_body         <= in_body_next;
      discarding      <= discarding_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt <= 3'd0;
    end else if (in_fire) begin
      cnt <= n_res;
    end else if (out_fire) begin
      cnt <= cnt - 3'd1;
    end
  end

  // result queue payload, head at entry 0
  always_ff @(posedge clk) begin
    if (in_fire) begin
      for (int k = 0; k < RES_DEPTH; k++) begin
        q[k] <= res[k];
      end
    end else if (out_fire) begin
      for (int k = 0; k < RES_DEPTH - 1; k++) begin
        q[k] <= q[k+1];
      end
    end
  end

endmodule

[design/lpfs_checker.sv]
// ----------------------------------------------------------------------------
// lpfs_checker
// Port-level checks for the frame splitter, bound to the top level.
// ----------------------------------------------------------------------------
`include "length_prefixed_frame_splitter_core_macros.svh"

module lpfs_checker
  import lpfs_pkg::*;
(
  input logic        clk,
  input logic        rst,
  input logic        out_valid,
  input logic        out_ready,
  input logic [7:0]  out_byte,
  input logic        first_of_frame,
  input logic        last_of_frame,
  input logic [1:0]  error_code
);

  // a stalled result keeps its payload
  `LPFS_ASSERT_NEXT(a_out_hold, clk, rst, out_valid && !out_ready, out_valid && $stable(out_byte) && $stable(error_code))

  // error results carry no byte or markers
  `LPFS_ASSERT_NOW(a_err_clean, clk, rst, out_valid && (error_code != ERR_NONE), (out_byte == 8'd0) && !first_of_frame && !last_of_frame)

  // first prefix byte is never also the last byte
  `LPFS_ASSERT_NOW(a_first_not_last, clk, rst, out_valid && first_of_frame, !last_of_frame && (error_code == ERR_NONE))

  // only defined error codes appear
  `LPFS_ASSERT_NOW(a_err_range, clk, rst, out_valid, (error_code == ERR_NONE) || (error_code == ERR_TOO_LONG) || (error_code == ERR_TOO_SHORT))

endmodule

bind length_prefixed_frame_splitter_core lpfs_checker u_lpfs_checker (.*);
